// File: hw/rtl/dsns_pkg.sv
package dsns_pkg;

    localparam int ADDR_W = 32;
    localparam int TS_W   = 32;
    localparam int LVL_W  = 16;
    localparam int OP_W   = 3;
    localparam int KIND_W = 2;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_FOUND  = 3'd0,
        OP_DOCK   = 3'd1,
        OP_UNDOCK = 3'd2,
        OP_ADD    = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 2'd0,
        KIND_FOUND    = 2'd1,
        KIND_DOCKED   = 2'd2,
        KIND_UNDOCKED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CMP,
        S_INS,
        S_PUT,
        S_FIN
    } t_state;

    typedef enum logic {
        CMP_EQ,
        CMP_GT
    } t_cmp_mode;

    typedef struct packed {
        logic [TS_W-1:0]  time_stamp;
        logic [LVL_W-1:0] level;
    } t_note;

endpackage

// File: hw/rtl/dsns_if.sv
interface dsns_in_if;
    import dsns_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [ADDR_W-1:0]       remote_address;
    logic signed [TS_W-1:0]  time_stamp;
    logic [LVL_W-1:0]        note_intensity;

    modport source (
        output valid, opcode, remote_address, time_stamp, note_intensity,
        input  ready
    );
    modport sink (
        input  valid, opcode, remote_address, time_stamp, note_intensity,
        output ready
    );
endinterface

interface dsns_out_if;
    import dsns_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [IDX_W-1:0]  device_index;
    logic              is_docked;
    logic [CNT_W-1:0]  notes_held;
    logic              overflow;

    modport source (
        output valid, event_kind, device_index, is_docked, notes_held, overflow,
        input  ready
    );
    modport sink (
        input  valid, event_kind, device_index, is_docked, notes_held, overflow,
        output ready
    );
endinterface

// File: hw/rtl/docked_device_sorted_note_store_unit.sv
// Channel  | Dir | Payload                                               | Handshake
// i_req    | in  | opcode, remote_address, time_stamp, note_intensity    | valid/ready
// o_rsp    | out | event_kind, device_index, is_docked, notes_held,      | valid/ready
//          |     | overflow                                              |
// One request at a time; i_req.ready is high only while the sequencer is idle.
// Found/docked: registry entries are compared one at a time until a match or the end
// (one shared compare unit, one read port of the address memory). Add note: each later
// note is shifted up one slot, then the new note is written. Undocked, clear, unknown, docked
// while docked, add while undocked or full: straight from execute to finish.
// Reset clears the registry count, docked flag and output valid; memories are not cleared.
// A stalled response holds in the output register; the next request is taken meanwhile.
module docked_device_sorted_note_store_unit #(
    parameter int MAX_DEVICES = 8,
    parameter int MAX_NOTES   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsns_in_if.sink   i_req,
    dsns_out_if.source o_rsp
);
    import dsns_pkg::*;

    localparam int DIW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int DCW    = $clog2(MAX_DEVICES + 1);
    localparam int PW     = $clog2(MAX_NOTES + 1);
    localparam int NDEPTH = MAX_DEVICES * MAX_NOTES;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int NOTE_W = $bits(t_note);

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op;
    logic [ADDR_W-1:0]      r_addr;
    logic signed [TS_W-1:0] r_ts;
    logic [LVL_W-1:0]       r_lvl;
    logic [DCW-1:0]         r_dev_count;
    logic [DCW-1:0]         r_i;
    logic [DIW-1:0]         r_slot;
    logic                   r_docked;
    logic [PW-1:0]          r_cur_count;
    logic [NAW-1:0]         r_base;
    logic [PW-1:0]          r_k;
    t_kind                  r_kind;
    logic [DIW-1:0]         r_index;
    logic                   r_ovf;

    logic                   r_o_valid;
    t_kind                  r_o_kind;
    logic [IDX_W-1:0]       r_o_index;
    logic                   r_o_docked;
    logic [CNT_W-1:0]       r_o_notes;
    logic                   r_o_ovf;

    logic                   accept;
    logic                   out_free;
    logic                   scan_end;
    logic                   full_dev;
    logic                   full_note;
    logic                   k_zero;

    t_cmp_mode              cmp_mode;
    logic [ADDR_W-1:0]      cmp_a;
    logic [ADDR_W-1:0]      cmp_b;
    logic                   hit;

    logic                   dev_we;
    logic [DIW-1:0]         dev_raddr;
    logic [ADDR_W-1:0]      dev_rdata;
    logic                   cnt_we;
    logic [DIW-1:0]         cnt_waddr;
    logic [PW-1:0]          cnt_wdata;
    logic [PW-1:0]          cnt_rdata;
    logic                   note_we;
    logic [NAW-1:0]         note_waddr;
    t_note                  note_wdata;
    logic [NAW-1:0]         note_raddr;
    logic [NOTE_W-1:0]      note_rdata_raw;
    t_note                  note_rdata;
    t_note                  new_note;

    assign accept     = i_req.valid && i_req.ready;
    assign out_free   = !r_o_valid || o_rsp.ready;
    assign scan_end   = (r_i == r_dev_count);
    assign full_dev   = (r_dev_count == DCW'(MAX_DEVICES));
    assign full_note  = (r_cur_count == PW'(MAX_NOTES));
    assign k_zero     = (r_k == '0);
    assign note_rdata = t_note'(note_rdata_raw);
    assign new_note   = '{time_stamp: r_ts, level: r_lvl};
    assign dev_raddr  = r_i[DIW-1:0];

    dsns_cmp u_cmp (
        .i_mode (cmp_mode),
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_hit  (hit)
    );

    dsns_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_DEVICES)) u_dev_ram (
        .i_clk   (i_clk),
        .i_we    (dev_we),
        .i_waddr (r_i[DIW-1:0]),
        .i_wdata (r_addr),
        .i_raddr (dev_raddr),
        .o_rdata (dev_rdata)
    );

    dsns_ram #(.WIDTH(PW), .DEPTH(MAX_DEVICES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (dev_raddr),
        .o_rdata (cnt_rdata)
    );

    dsns_ram #(.WIDTH(NOTE_W), .DEPTH(NDEPTH)) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (note_we),
        .i_waddr (note_waddr),
        .i_wdata (NOTE_W'(note_wdata)),
        .i_raddr (note_raddr),
        .o_rdata (note_rdata_raw)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_FOUND: n_state = S_SCAN;
                    OP_DOCK:  n_state = r_docked ? S_FIN : S_SCAN;
                    OP_ADD: begin
                        if (!r_docked || full_note) begin
                            n_state = S_FIN;
                        end else if (r_cur_count == '0) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                    default:  n_state = S_FIN;
                endcase
            end
            S_SCAN:  n_state = scan_end ? S_FIN : S_CMP;
            S_CMP:   n_state = hit ? S_FIN : S_SCAN;
            S_INS: begin
                if (!hit) begin
                    n_state = S_FIN;
                end else if (k_zero) begin
                    n_state = S_PUT;
                end
            end
            S_PUT:   n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        cmp_mode    = CMP_EQ;
        cmp_a       = dev_rdata;
        cmp_b       = r_addr;
        dev_we      = 1'b0;
        cnt_we      = 1'b0;
        cnt_waddr   = r_slot;
        cnt_wdata   = r_cur_count + PW'(1);
        note_we     = 1'b0;
        note_waddr  = r_base + NAW'(r_k + PW'(1));
        note_wdata  = new_note;
        note_raddr  = r_base + NAW'(r_k - PW'(1));
        unique case (r_state)
            S_EXEC: begin
                note_raddr = r_base + NAW'(r_cur_count - PW'(1));
                if (r_op == OP_CLEAR && r_docked) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = '0;
                end
            end
            S_SCAN: begin
                if (scan_end && r_op == OP_FOUND && !full_dev) begin
                    dev_we    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_waddr = r_i[DIW-1:0];
                    cnt_wdata = '0;
                end
            end
            S_INS: begin
                cmp_mode = CMP_GT;
                cmp_a    = note_rdata.time_stamp;
                cmp_b    = r_ts;
                note_we  = 1'b1;
                if (hit) begin
                    note_wdata = note_rdata;
                end else begin
                    cnt_we = 1'b1;
                end
            end
            S_PUT: begin
                note_we    = 1'b1;
                note_waddr = r_base + NAW'(r_k);
                cnt_we     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dev_count <= '0;
            r_docked    <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN && scan_end && r_op == OP_FOUND && !full_dev) begin
                r_dev_count <= r_dev_count + DCW'(1);
            end
            if (r_state == S_EXEC && r_op == OP_UNDOCK) begin
                r_docked <= 1'b0;
            end else if (r_state == S_CMP && hit && r_op == OP_DOCK) begin
                r_docked <= 1'b1;
            end
            if (r_state == S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_req.opcode;
            r_addr  <= i_req.remote_address;
            r_ts    <= i_req.time_stamp;
            r_lvl   <= i_req.note_intensity;
            r_i     <= '0;
            r_kind  <= KIND_NONE;
            r_index <= '0;
            r_ovf   <= 1'b0;
        end
        unique case (r_state)
            S_EXEC: begin
                if (r_docked) begin
                    unique case (r_op)
                        OP_UNDOCK: begin
                            r_kind  <= KIND_UNDOCKED;
                            r_index <= r_slot;
                        end
                        OP_ADD: begin
                            if (full_note) begin
                                r_ovf <= 1'b1;
                            end
                            r_k <= (r_cur_count == '0) ? '0 : r_cur_count - PW'(1);
                        end
                        OP_CLEAR: r_cur_count <= '0;
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_end && r_op == OP_FOUND) begin
                    if (full_dev) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_kind  <= KIND_FOUND;
                        r_index <= r_i[DIW-1:0];
                    end
                end
            end
            S_CMP: begin
                if (hit) begin
                    if (r_op == OP_DOCK) begin
                        r_slot      <= r_i[DIW-1:0];
                        r_kind      <= KIND_DOCKED;
                        r_index     <= r_i[DIW-1:0];
                        r_cur_count <= cnt_rdata;
                        r_base      <= NAW'(r_i[DIW-1:0]) * NAW'(MAX_NOTES);
                    end
                end else begin
                    r_i <= r_i + DCW'(1);
                end
            end
            S_INS: begin
                if (hit) begin
                    if (!k_zero) begin
                        r_k <= r_k - PW'(1);
                    end
                end else begin
                    r_cur_count <= r_cur_count + PW'(1);
                end
            end
            S_PUT:   r_cur_count <= r_cur_count + PW'(1);
            default: begin
            end
        endcase
        if (r_state == S_FIN && out_free) begin
            r_o_kind   <= r_kind;
            r_o_index  <= IDX_W'(r_index);
            r_o_docked <= r_docked;
            r_o_notes  <= r_docked ? CNT_W'(r_cur_count) : '0;
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.event_kind   = r_o_kind;
    assign o_rsp.device_index = r_o_index;
    assign o_rsp.is_docked    = r_o_docked;
    assign o_rsp.notes_held   = r_o_notes;
    assign o_rsp.overflow     = r_o_ovf;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while a request is in progress");

    a_dev_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dev_count <= DCW'(MAX_DEVICES))
        else $error("registry count beyond capacity");

    a_notes_need_dock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.is_docked) |-> (o_rsp.notes_held == '0))
        else $error("notes reported with no docked device");

    a_note_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_docked && r_state == S_IDLE) |-> (r_cur_count <= PW'(MAX_NOTES)))
        else $error("note count beyond capacity");

endmodule

// File: hw/rtl/dsns_ram.sv
module dsns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/dsns_cmp.sv
module dsns_cmp (
    input  dsns_pkg::t_cmp_mode             i_mode,
    input  logic [dsns_pkg::ADDR_W-1:0]     i_a,
    input  logic [dsns_pkg::ADDR_W-1:0]     i_b,
    output logic                            o_hit
);
    import dsns_pkg::*;

    always_comb begin
        unique case (i_mode)
            CMP_EQ:  o_hit = (i_a == i_b);
            CMP_GT:  o_hit = ($signed(i_a) > $signed(i_b));
            default: o_hit = 1'b0;
        endcase
    end
endmodule

// File: sim/tb_docked_device_sorted_note_store_unit.sv
module tb_docked_device_sorted_note_store_unit;
    import dsns_pkg::*;

    localparam int MAX_DEV      = 8;
    localparam int MAX_NOTE     = 32;
    localparam int RAND_ITEMS   = 1600;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int TAIL_CYCLES  = 64;
    localparam int OP_TOP       = (1 << OP_W) - 1;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        logic              docked;
        logic [CNT_W-1:0]  held;
        logic              overflow;
    } t_note_result;

    class dock_note_tracker;
        logic [ADDR_W-1:0]      dev_addr [MAX_DEV];
        int                     dev_count;
        int                     dock_slot;
        bit                     dock_flag;
        logic signed [TS_W-1:0] note_ts  [MAX_DEV][MAX_NOTE];
        logic [LVL_W-1:0]       note_lvl [MAX_DEV][MAX_NOTE];
        int                     note_cnt [MAX_DEV];
        t_note_result           due_results[$];
        int                     faults;

        function new();
            dev_count = 0;
            dock_slot = 0;
            dock_flag = 1'b0;
            faults    = 0;
            foreach (note_cnt[d]) note_cnt[d] = 0;
        endfunction

        function void insert_note(int s, logic signed [TS_W-1:0] ts, logic [LVL_W-1:0] lvl);
            int n;
            int p;
            n = note_cnt[s];
            p = 0;
            while (p < n && !(note_ts[s][p] > ts)) p++;
            for (int k = n; k > p; k--) begin
                note_ts[s][k]  = note_ts[s][k-1];
                note_lvl[s][k] = note_lvl[s][k-1];
            end
            note_ts[s][p]  = ts;
            note_lvl[s][p] = lvl;
            note_cnt[s]    = n + 1;
        endfunction

        function bit take_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                  logic signed [TS_W-1:0] ts, logic [LVL_W-1:0] lvl);
            t_note_result r;
            bit           hit;
            bit           acted;
            r.kind     = KIND_NONE;
            r.index    = '0;
            r.overflow = 1'b0;
            acted      = 1'b0;
            case (op)
                OP_FOUND: begin
                    hit = 1'b0;
                    for (int i = 0; i < dev_count; i++)
                        if (dev_addr[i] == addr) hit = 1'b1;
                    if (!hit) begin
                        if (dev_count < MAX_DEV) begin
                            dev_addr[dev_count] = addr;
                            note_cnt[dev_count] = 0;
                            r.index = IDX_W'(dev_count);
                            r.kind  = KIND_FOUND;
                            dev_count++;
                        end else begin
                            r.overflow = 1'b1;
                        end
                    end
                end
                OP_DOCK: begin
                    if (!dock_flag) begin
                        for (int i = 0; i < dev_count; i++) begin
                            if (!dock_flag && dev_addr[i] == addr) begin
                                dock_slot = i;
                                dock_flag = 1'b1;
                                r.kind    = KIND_DOCKED;
                                r.index   = IDX_W'(i);
                            end
                        end
                    end
                end
                OP_UNDOCK: begin
                    if (dock_flag) begin
                        r.kind    = KIND_UNDOCKED;
                        r.index   = IDX_W'(dock_slot);
                        dock_flag = 1'b0;
                    end
                end
                OP_ADD: begin
                    if (dock_flag) begin
                        acted = 1'b1;
                        if (note_cnt[dock_slot] < MAX_NOTE) insert_note(dock_slot, ts, lvl);
                        else r.overflow = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    if (dock_flag) begin
                        acted = 1'b1;
                        note_cnt[dock_slot] = 0;
                    end
                end
                default: ;
            endcase
            r.docked = dock_flag;
            r.held   = dock_flag ? CNT_W'(note_cnt[dock_slot]) : '0;
            due_results.push_back(r);
            return acted || r.overflow || r.kind != KIND_NONE;
        endfunction

        function void match_result(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] index,
                                   logic docked, logic [CNT_W-1:0] held, logic overflow);
            t_note_result w;
            if (due_results.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: kind=%0d idx=%0d docked=%0b held=%0d ovf=%0b",
                             kind, index, docked, held, overflow);
                return;
            end
            w = due_results.pop_front();
            if (w.kind !== kind || w.index !== index || w.docked !== docked ||
                w.held !== held || w.overflow !== overflow) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected kind=%0d idx=%0d docked=%0b held=%0d ovf=%0b, %s",
                             w.kind, w.index, w.docked, w.held, w.overflow,
                             $sformatf("got kind=%0d idx=%0d docked=%0b held=%0d ovf=%0b",
                                       kind, index, docked, held, overflow));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   useful;
    int   cycles;

    dock_note_tracker tracker;

    dsns_in_if  req_bus();
    dsns_out_if rsp_bus();

    docked_device_sorted_note_store_unit #(
        .MAX_DEVICES(MAX_DEV),
        .MAX_NOTES  (MAX_NOTE)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("FAIL docked_device_sorted_note_store_unit");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            tracker.match_result(rsp_bus.event_kind, rsp_bus.device_index, rsp_bus.is_docked,
                                 rsp_bus.notes_held, rsp_bus.overflow);
        rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    function automatic logic signed [TS_W-1:0] pick_stamp();
        int d;
        case ($urandom_range(0, 7))
            4, 5: begin
                d = $urandom_range(0, 15);
                return d - 8;
            end
            6: return {1'b1, {(TS_W-1){1'b0}}};
            7: return {1'b0, {(TS_W-1){1'b1}}};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                            logic signed [TS_W-1:0] ts, logic [LVL_W-1:0] lvl);
        while (!calm && $urandom_range(0, 99) < 20) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.opcode         <= op;
        req_bus.remote_address <= addr;
        req_bus.time_stamp     <= ts;
        req_bus.note_intensity <= lvl;
        do @(posedge i_clk); while (!req_bus.ready);
        if (tracker.take_request(op, addr, ts, lvl)) useful++;
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_note();
        send_req(OP_ADD, $urandom, pick_stamp(), LVL_W'($urandom));
    endtask

    function automatic logic [ADDR_W-1:0] listed_addr();
        return tracker.dev_addr[$urandom_range(0, tracker.dev_count - 1)];
    endfunction

    task automatic dock_session();
        int n;
        if ($urandom_range(0, 3) == 0)
            send_req(OP_CLEAR, $urandom, pick_stamp(), LVL_W'($urandom));
        send_req(OP_DOCK, listed_addr(), pick_stamp(), LVL_W'($urandom));
        if ($urandom_range(0, 3) == 0)
            send_req(OP_CLEAR, $urandom, pick_stamp(), LVL_W'($urandom));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0)
                send_req(OP_CLEAR, $urandom, pick_stamp(), LVL_W'($urandom));
            else send_note();
        end
        if ($urandom_range(0, 4) == 0)
            send_req(OP_DOCK, listed_addr(), pick_stamp(), LVL_W'($urandom));
        send_req(OP_UNDOCK, $urandom, pick_stamp(), LVL_W'($urandom));
    endtask

    task automatic send_noise();
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(0, OP_TOP));
        if ((op == OP_FOUND || op == OP_DOCK) && $urandom_range(0, 1) == 0)
            send_req(op, listed_addr(), pick_stamp(), LVL_W'($urandom));
        else
            send_req(op, $urandom, pick_stamp(), LVL_W'($urandom));
    endtask

    initial begin
        tracker = new();
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        calm    = 1'b0;
        useful  = 0;
        cycles  = 0;
        req_bus.valid          = 1'b0;
        req_bus.opcode         = OP_FOUND;
        req_bus.remote_address = '0;
        req_bus.time_stamp     = '0;
        req_bus.note_intensity = '0;
        rsp_bus.ready          = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(OP_ADD, '0, pick_stamp(), '1);
        send_req(OP_CLEAR, '0, pick_stamp(), '0);
        send_req(OP_UNDOCK, '0, pick_stamp(), '0);
        send_req(OP_DOCK, '0, pick_stamp(), '0);
        send_req(OP_FOUND, '0, '0, '0);
        send_req(OP_FOUND, '0, '0, '0);
        send_req(OP_FOUND, '1, '1, '1);
        send_req(OP_DOCK, '1, '0, '0);
        send_req(OP_DOCK, '0, '0, '0);
        send_req(OP_ADD, '1, {1'b1, {(TS_W-1){1'b0}}}, '0);
        send_req(OP_ADD, '0, {1'b0, {(TS_W-1){1'b1}}}, '1);
        send_req(OP_ADD, '0, '0, 16'd1);
        send_req(OP_ADD, '0, '0, 16'd2);
        send_req(OP_CLEAR, '0, '0, '0);
        send_req(OP_UNDOCK, '0, '0, '0);
        for (int op = OP_CLEAR + 1; op <= OP_TOP; op++)
            send_req(OP_W'(op), $urandom, pick_stamp(), LVL_W'($urandom));
        repeat (MAX_DEV - 2) send_req(OP_FOUND, $urandom, pick_stamp(), LVL_W'($urandom));
        send_req(OP_FOUND, $urandom, pick_stamp(), LVL_W'($urandom));
        drain();

        useful = 0;
        while (useful < RAND_ITEMS) begin
            calm = (useful >= 600 && useful < 900);
            if ($urandom_range(0, 99) < 70) dock_session();
            else send_noise();
            if ($urandom_range(0, 29) == 0) drain();
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.due_results.size() == 0) begin
            $display("PASS docked_device_sorted_note_store_unit");
        end else begin
            $display("FAIL docked_device_sorted_note_store_unit");
        end
        $finish;
    end

endmodule
